// ----- design/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the clamped PID controller
// Operation word of the shared multiply-accumulate unit, divider status and
// the shift codes that place a partial product in the accumulator.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int ACC_W = 74;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  typedef struct packed {
    logic                    issue;
    logic                    load;
    logic [1:0]              shift;
    logic signed [24:0]      a;
    logic signed [16:0]      b;
    logic signed [ACC_W-1:0] init;
  } mac_op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- design/pid_controller_clamped_core.sv -----
// ----------------------------------------------------------------------------
// pid_controller_clamped_core: PID controller with clamped, negated output
// Serial divider forms the derivative, one shared multiply-accumulate unit
// forms the integral update and the three gain products, then clamp.
//
//   channel  dir  tdata                                tuser
//   in_      in   [15:0] track_error [31:16] step_time  -
//   out_     out  [15:0] drive                          [0] clipped
//   cfg_     in   cfg_index selects, cfg_wdata value    -
//
// An item whose step_time is nonzero waits for the serial divider; when
// step_time is zero the divider is skipped and the item takes only the
// seven passes through the multiply-accumulate unit. The next item can be
// accepted in the cycle after the result is registered.
// One item at a time; in_tready is high only while the sequencer is idle.
// The result register frees the input side while out_tready is low.
// Reset or any configuration write clears the previous error and integral.
// ----------------------------------------------------------------------------
module pid_controller_clamped_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] track_error, [31:16] step_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] drive
  output logic        out_tuser,  // [0] clipped
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_INTEG = 3'd1;
  localparam logic [2:0] REG_DERIV = 3'd2;
  localparam logic [2:0] REG_MAX   = 3'd3;
  localparam logic [2:0] REG_MIN   = 3'd4;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INTEG  = 4'd1;
  localparam logic [3:0] S_INTW   = 4'd2;
  localparam logic [3:0] S_INTSAT = 4'd3;
  localparam logic [3:0] S_DIVW   = 4'd4;
  localparam logic [3:0] S_MAC    = 4'd5;
  localparam logic [3:0] S_MACW   = 4'd6;
  localparam logic [3:0] S_NEG    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  localparam int AW = pcc_pkg::ACC_W;

  logic [3:0] state_r, state_nxt;
  logic [2:0] step_r;

  logic signed [23:0] prop_r, integ_r, deriv_r;
  logic signed [15:0] out_max_r, out_min_r;
  logic signed [15:0] last_error_r;
  logic signed [47:0] integral_r;

  logic signed [15:0] e_r;
  logic [15:0]        dt_r;
  logic               neg_r;
  logic signed [31:0] d_r;
  logic signed [58:0] c_r;

  logic               out_valid_r;
  logic [15:0]        out_drive_r;
  logic               out_clip_r;

  logic               accept;
  logic signed [15:0] in_err;
  logic [15:0]        in_dt;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic               div_start;
  logic [31:0]        quotient;
  pcc_pkg::div_stat_t div_stat;
  pcc_pkg::mac_op_t   mac_op;
  logic signed [AW-1:0] acc;
  logic               integ_ovf;
  logic signed [31:0] d_sat;
  logic signed [58:0] max_ext, min_ext;
  logic               out_free;

  assign in_err    = in_tdata[15:0];
  assign in_dt     = in_tdata[31:16];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign diff      = {in_err[15], in_err} - {last_error_r[15], last_error_r};
  assign diff_mag  = diff[16] ? (17'd0 - diff) : diff;
  assign div_start = accept && (in_dt != 16'd0);

  pcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({diff_mag[15:0], 16'd0}),
    .divisor  (in_dt),
    .quotient (quotient),
    .stat     (div_stat)
  );

  pcc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .acc   (acc)
  );

  // saturate the signed quotient to 32 bits
  always_comb begin
    if (neg_r) begin
      d_sat = quotient[31] ? 32'sh8000_0000 : $signed(32'd0 - quotient);
    end else begin
      d_sat = quotient[31] ? 32'sh7FFF_FFFF : $signed(quotient);
    end
  end

  assign integ_ovf = (acc[AW-1:47] != {(AW-47){acc[AW-1]}});
  assign max_ext   = {{27{out_max_r[15]}}, out_max_r, 16'd0};
  assign min_ext   = {{27{out_min_r[15]}}, out_min_r, 16'd0};
  assign out_free  = !out_valid_r || out_tready;

  // operation issued to the shared multiply-accumulate unit
  always_comb begin
    mac_op       = '0;
    mac_op.shift = pcc_pkg::SH_0;
    if (state_r == S_INTEG) begin
      mac_op.issue = 1'b1;
      mac_op.load  = 1'b1;
      mac_op.init  = {{(AW-48){integral_r[47]}}, integral_r};
      mac_op.a     = {{9{e_r[15]}}, e_r};
      mac_op.b     = {1'b0, dt_r};
    end else if (state_r == S_MAC) begin
      mac_op.issue = 1'b1;
      case (step_r)
        3'd0: begin
          mac_op.load  = 1'b1;
          mac_op.a     = {prop_r[23], prop_r};
          mac_op.b     = {e_r[15], e_r};
          mac_op.shift = pcc_pkg::SH_16;
        end
        3'd1: begin
          mac_op.a     = {deriv_r[23], deriv_r};
          mac_op.b     = {1'b0, d_r[15:0]};
          mac_op.shift = pcc_pkg::SH_16;
        end
        3'd2: begin
          mac_op.a     = {deriv_r[23], deriv_r};
          mac_op.b     = {d_r[31], d_r[31:16]};
          mac_op.shift = pcc_pkg::SH_32;
        end
        3'd3: begin
          mac_op.a     = {integ_r[23], integ_r};
          mac_op.b     = {1'b0, integral_r[15:0]};
          mac_op.shift = pcc_pkg::SH_0;
        end
        3'd4: begin
          mac_op.a     = {integ_r[23], integ_r};
          mac_op.b     = {1'b0, integral_r[31:16]};
          mac_op.shift = pcc_pkg::SH_16;
        end
        default: begin
          mac_op.a     = {integ_r[23], integ_r};
          mac_op.b     = {integral_r[47], integral_r[47:32]};
          mac_op.shift = pcc_pkg::SH_32;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_INTEG;
      S_INTEG:  state_nxt = S_INTW;
      S_INTW:   state_nxt = S_INTSAT;
      S_INTSAT: state_nxt = S_DIVW;
      S_DIVW:   if (dt_r == 16'd0 || div_stat.done) state_nxt = S_MAC;
      S_MAC:    if (step_r == 3'd5) state_nxt = S_MACW;
      S_MACW:   state_nxt = S_NEG;
      S_NEG:    state_nxt = S_FIN;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      prop_r       <= '0;
      integ_r      <= '0;
      deriv_r      <= '0;
      out_max_r    <= 16'sd32767;
      out_min_r    <= -16'sd32768;
      last_error_r <= '0;
      integral_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_MAC) begin
        step_r <= step_r + 3'd1;
      end else begin
        step_r <= '0;
      end

      if (accept) begin
        last_error_r <= in_err;
      end

      // hold the saturated integral once the update has landed
      if (state_r == S_INTSAT && dt_r != 16'd0) begin
        if (integ_ovf) begin
          integral_r <= acc[AW-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
          integral_r <= acc[47:0];
        end
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROP:  prop_r    <= cfg_wdata;
          REG_INTEG: integ_r   <= cfg_wdata;
          REG_DERIV: deriv_r   <= cfg_wdata;
          REG_MAX:   out_max_r <= cfg_wdata[15:0];
          REG_MIN:   out_min_r <= cfg_wdata[15:0];
          default:   ;
        endcase
        last_error_r <= '0;
        integral_r   <= '0;
      end

      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_r   <= in_err;
      dt_r  <= in_dt;
      neg_r <= diff[16];
    end
    if (state_r == S_DIVW) begin
      d_r <= (dt_r == 16'd0) ? 32'sd0 : d_sat;
    end
    if (state_r == S_NEG) begin
      c_r <= 59'sd0 - {acc[AW-1], acc[AW-1:16]};
    end
    // upper limit is tested first
    if (state_r == S_FIN && out_free) begin
      if (c_r > max_ext) begin
        out_drive_r <= out_max_r;
        out_clip_r  <= 1'b1;
      end else if (c_r < min_ext) begin
        out_drive_r <= out_min_r;
        out_clip_r  <= 1'b1;
      end else begin
        out_drive_r <= c_r[31:16];
        out_clip_r  <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_clip_r;

`ifndef ASSERT_OFF
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIVW))
    else $error("divider finished outside the wait state");

  a_accept_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_INTEG))
    else $error("accepted item did not start the sequence");

  a_mac_busy_only: assert property (@(posedge clk) disable iff (!rst_n)
    mac_op.issue |-> (state_r != S_IDLE) && !in_tready)
    else $error("mac operation issued while idle");

  a_div_not_started_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule

// ----- design/pcc_div.sv -----
// ----------------------------------------------------------------------------
// pcc_div: serial unsigned divider
// Restoring division of a 32-bit dividend by a nonzero 16-bit divisor, one
// quotient bit per cycle. done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module pcc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        dividend,
  input  logic [15:0]        divisor,
  output logic [31:0]        quotient,
  output pcc_pkg::div_stat_t stat
);

  logic [16:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] dsr_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] rem_sh;
  logic        fits;

  always_comb begin
    rem_sh  = {rem_r[15:0], quo_r[31]};
    fits    = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = fits ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
    quo_nxt = {quo_r[30:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- design/pcc_mac.sv -----
// ----------------------------------------------------------------------------
// pcc_mac: shared multiply-accumulate unit
// 25x17 signed multiply, shifted and registered, then added into a 74-bit
// accumulator. An operation with load set starts from its init value.
// ----------------------------------------------------------------------------
module pcc_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pcc_pkg::mac_op_t                 op,
  output logic signed [pcc_pkg::ACC_W-1:0] acc
);

  logic signed [41:0]                 prod;
  logic signed [pcc_pkg::ACC_W-1:0]   prod_ext;
  logic signed [pcc_pkg::ACC_W-1:0]   prod_sh;
  logic signed [pcc_pkg::ACC_W-1:0]   prod_r;
  logic signed [pcc_pkg::ACC_W-1:0]   init_r;
  logic signed [pcc_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic                               pv_r;
  logic                               load_r;

  assign prod     = op.a * op.b;
  assign prod_ext = {{(pcc_pkg::ACC_W-42){prod[41]}}, prod};

  always_comb begin
    case (op.shift)
      pcc_pkg::SH_0:  prod_sh = prod_ext;
      pcc_pkg::SH_16: prod_sh = prod_ext <<< 16;
      pcc_pkg::SH_32: prod_sh = prod_ext <<< 32;
      default:        prod_sh = prod_ext;
    endcase
  end

  assign acc_nxt = (load_r ? init_r : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= op.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (op.issue) begin
      prod_r <= prod_sh;
      init_r <= op.init;
      load_r <= op.load;
    end
    if (pv_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ----- tb/pcc_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_tb_pkg: register map and result type for the PID controller bench
// Register indexes of the configuration port and the packed form of one
// controller result, shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
package pcc_tb_pkg;

  localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [2:0] REG_OUT_MAX    = 3'd3;
  localparam logic [2:0] REG_OUT_MIN    = 3'd4;
  // first index past the map; writes there only clear the loop state
  localparam logic [2:0] REG_SPARE      = 3'd5;

  typedef struct packed {
    logic [15:0] drive;
    logic        clipped;
  } drive_t;

endpackage

// ----- tb/pcc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_checker: scoreboard for the clamped PID controller
// Tracks gains, limits, previous error and integral from the configuration
// and input handshakes, computes each expected drive and clip flag in wide
// signed arithmetic, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module pcc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] track_error, [31:16] step_time
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] drive
  input  logic        out_tuser,  // [0] clipped
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  localparam logic signed [79:0] DERIV_MAX = 80'sd2147483647;
  localparam logic signed [79:0] DERIV_MIN = -80'sd2147483648;
  localparam logic signed [79:0] INTEG_MAX = 80'sd140737488355327;
  localparam logic signed [79:0] INTEG_MIN = -80'sd140737488355328;

  logic signed [23:0]  gain_p, gain_i, gain_d;
  logic signed [15:0]  lim_hi, lim_lo;
  logic signed [15:0]  prev_err;
  logic signed [47:0]  integ_acc;
  pcc_tb_pkg::drive_t  pending_drives[$];

  function automatic void apply_write(input logic [2:0] idx, input logic [23:0] val);
    case (idx)
      pcc_tb_pkg::REG_PROP_GAIN:  gain_p = val;
      pcc_tb_pkg::REG_INTEG_GAIN: gain_i = val;
      pcc_tb_pkg::REG_DERIV_GAIN: gain_d = val;
      pcc_tb_pkg::REG_OUT_MAX:    lim_hi = val[15:0];
      pcc_tb_pkg::REG_OUT_MIN:    lim_lo = val[15:0];
      default: ;
    endcase
    // any write restarts the loop
    prev_err  = '0;
    integ_acc = '0;
  endfunction

  function automatic pcc_tb_pkg::drive_t control_step(input logic signed [15:0] err,
                                                      input logic [15:0] dt);
    logic signed [79:0] e_w, dt_w, deriv, isum, ctrl;
    logic signed [79:0] kp_w, ki_w, kd_w, hi_w, lo_w;
    pcc_tb_pkg::drive_t r;
    e_w   = err;
    dt_w  = dt;
    kp_w  = gain_p;
    ki_w  = gain_i;
    kd_w  = gain_d;
    hi_w  = lim_hi;
    lo_w  = lim_lo;
    isum  = integ_acc;
    deriv = '0;
    if (dt != 16'd0) begin
      // signed division truncates toward zero
      deriv = ((e_w - prev_err) * 80'sd65536) / dt_w;
      if (deriv > DERIV_MAX) deriv = DERIV_MAX;
      if (deriv < DERIV_MIN) deriv = DERIV_MIN;
    end
    prev_err = err;
    isum = isum + e_w * dt_w;
    if (isum > INTEG_MAX) isum = INTEG_MAX;
    if (isum < INTEG_MIN) isum = INTEG_MIN;
    integ_acc = isum[47:0];
    ctrl = -(kp_w * e_w + kd_w * deriv + ((ki_w * isum) >>> 16));
    r.clipped = 1'b1;
    // upper limit wins when the limits are crossed
    if (ctrl > (hi_w <<< 16)) begin
      r.drive = lim_hi;
    end else if (ctrl < (lo_w <<< 16)) begin
      r.drive = lim_lo;
    end else begin
      r.drive   = ctrl[31:16];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pcc_tb_pkg::drive_t want;
    int                 errs;
    errs = 0;
    if (!rst_n) begin
      gain_p    = '0;
      gain_i    = '0;
      gain_d    = '0;
      lim_hi    = 16'sh7FFF;
      lim_lo    = 16'sh8000;
      prev_err  = '0;
      integ_acc = '0;
      pending_drives.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready)
        pending_drives.push_back(control_step(in_tdata[15:0], in_tdata[31:16]));
      if (out_tvalid && out_tready) begin
        if (pending_drives.size() == 0) begin
          $error("result with no item pending: drive %0d clipped %0b",
                 $signed(out_tdata), out_tuser);
          errs++;
        end else begin
          want = pending_drives.pop_front();
          if (out_tdata !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(out_tdata));
            errs++;
          end
          if (out_tuser !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, out_tuser);
            errs++;
          end
        end
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= pending_drives.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the clamped PID controller
// Directed items hit field extremes, derivative saturation, zero steps,
// exact and crossed clamp limits and the state clear on any register write;
// a gap-free run under a steady receiver pushes the integral hard negative;
// random phases then vary gains, limits and items under bursty input and
// stalling output.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int SAT_ITEMS     = 30;
  localparam int RAND_PHASES   = 7;
  localparam int PHASE_ITEMS   = 92;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [15:0] track_error, [31:16] step_time
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] drive
  logic        out_tuser;         // [0] clipped
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [23:0] cfg_wdata  = '0;

  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;
  int          burst_left  = 0;
  logic        rx_steady   = 1'b0;
  int          rx_mode     = 0;
  int          rx_left     = 0;
  int          rx_hold     = 0;
  logic [15:0] err_trail   = '0;

  pid_controller_clamped_core uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  pcc_checker drive_chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .outstanding
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CLK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: switch between stall patterns after a random run of each
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 400);
    end else begin
      rx_left--;
    end
    if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 7) == 0);
        default: begin
          // long stall, then a single ready cycle
          if (rx_hold == 0) begin
            out_tready <= 1'b1;
            rx_hold = $urandom_range(10, 80);
          end else begin
            out_tready <= 1'b0;
            rx_hold--;
          end
        end
      endcase
    end
  end

  task automatic push_item(input logic [15:0] err, input logic [15:0] dt, input bit paced);
    in_tvalid <= 1'b1;
    in_tdata  <= {dt, err};
    do @(posedge clk); while (!in_tready);
    if (paced) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  // hold off new items until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [23:0] kp, input logic [23:0] ki,
                               input logic [23:0] kd, input logic [23:0] hi,
                               input logic [23:0] lo);
    write_reg(pcc_tb_pkg::REG_PROP_GAIN, kp);
    write_reg(pcc_tb_pkg::REG_INTEG_GAIN, ki);
    write_reg(pcc_tb_pkg::REG_DERIV_GAIN, kd);
    write_reg(pcc_tb_pkg::REG_OUT_MAX, hi);
    write_reg(pcc_tb_pkg::REG_OUT_MIN, lo);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick_gain();
    int v;
    v = int'($urandom_range(0, 262144)) - 131072;
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3, 4: return v[23:0];
      default: return 24'($urandom);
    endcase
  endfunction

  // limits carry random upper bits, which the block must ignore
  function automatic logic [23:0] pick_limit();
    int v;
    v = int'($urandom_range(0, 4096)) - 2048;
    case ($urandom_range(0, 4))
      0: return 24'h007FFF;
      1: return 24'h008000;
      2: return 24'($urandom);
      default: return {8'($urandom), v[15:0]};
    endcase
  endfunction

  function automatic logic [15:0] pick_error();
    int v;
    v = int'($urandom_range(0, 600)) - 300;
    case ($urandom_range(0, 7))
      0: err_trail = 16'h7FFF;
      1: err_trail = 16'h8000;
      2: err_trail = 16'h0000;
      3, 4: err_trail = err_trail + v[15:0];  // slow drift around the last value
      default: err_trail = 16'($urandom);
    endcase
    return err_trail;
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: all gains zero
    push_item(16'h7FFF, 16'hFFFF, 1'b1);
    push_item(16'h8000, 16'h0000, 1'b1);

    drain();
    load_settings(24'h010000, 24'h001000, 24'h000100, 24'h007FFF, 24'h008000);
    push_item(16'h0000, 16'h0000, 1'b1);
    push_item(16'h7FFF, 16'h0001, 1'b1);  // derivative stays just below saturation
    push_item(16'h8000, 16'h0001, 1'b1);  // derivative saturates low
    push_item(16'h8000, 16'h0000, 1'b1);  // zero step
    push_item(16'h0001, 16'h0003, 1'b1);
    push_item(16'hFFFF, 16'h0003, 1'b1);  // negative quotient truncates toward zero
    push_item(16'h7FFF, 16'hFFFF, 1'b1);
    push_item(16'h0000, 16'hFFFF, 1'b1);

    // unit gain, limits +-50: exact limit passes unclipped, one past clips
    drain();
    load_settings(24'h010000, 24'h000000, 24'h000000, 24'h000032, 24'h00FFCE);
    push_item(16'hFFCE, 16'h0001, 1'b1);
    push_item(16'hFFCD, 16'h0001, 1'b1);
    push_item(16'h0032, 16'h0001, 1'b1);
    push_item(16'h0033, 16'h0001, 1'b1);

    // crossed limits: max -100, min 100
    drain();
    load_settings(24'h010000, 24'h000000, 24'h000000, 24'h00FF9C, 24'h000064);
    push_item(16'hFF38, 16'h0000, 1'b1);
    push_item(16'h0000, 16'h0000, 1'b1);
    push_item(16'h00C8, 16'h0000, 1'b1);

    drain();
    load_settings(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h007FFF, 24'h008000);
    push_item(16'h8000, 16'hFFFF, 1'b1);
    push_item(16'h7FFF, 16'h0001, 1'b1);
    drain();
    load_settings(24'h800000, 24'h800000, 24'h800000, 24'h007FFF, 24'h008000);
    push_item(16'h7FFF, 16'hFFFF, 1'b1);
    push_item(16'h8000, 16'h0001, 1'b1);

    // a write past the map clears previous error and integral only
    drain();
    write_reg(pcc_tb_pkg::REG_SPARE, 24'hFFFFFF);
    cfg_we <= 1'b0;
    push_item(16'h0100, 16'h0002, 1'b1);

    // gain -1.0 on the most negative error with a tiny integral gain;
    // items follow with no gaps into a receiver that never stalls
    drain();
    load_settings(24'hFF0000, 24'h000001, 24'h000000, 24'h007FFF, 24'h008000);
    rx_steady <= 1'b1;
    for (int n = 0; n < SAT_ITEMS; n++) push_item(16'h8000, 16'hFFFF, 1'b0);
    push_item(16'h7FFF, 16'hFFFF, 1'b0);
    push_item(16'h0000, 16'h8000, 1'b0);
    drain();
    rx_steady <= 1'b0;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == PHASE_ITEMS / 2) drain();
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          drain();
          write_reg(pcc_tb_pkg::REG_SPARE + 3'($urandom_range(0, 2)), 24'($urandom));
          cfg_we <= 1'b0;
        end
        push_item(pick_error(), pick_step(), 1'b1);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pcc_pkg.sv
design/pcc_div.sv
design/pcc_mac.sv
design/pid_controller_clamped_core.sv
tb/pcc_tb_pkg.sv
tb/pcc_checker.sv
tb/tb_top.sv
